### rtl/core/nia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nia_pkg
// Shared types and constants for the navigation autorepeat block.
// ----------------------------------------------------------------------------
package nia_pkg;

	// direction codes
	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_DOWN  = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_NONE  = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_STICK_THRESHOLD = 2'd0;
	localparam logic [1:0] CFG_REPEAT_DELAY    = 2'd1;
	localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd2;
	localparam logic [1:0] CFG_PRESS_MAP       = 2'd3;

	localparam int CfgDataWidth = 20;
	localparam int CfgIndexWidth = 2;

	// configuration reset values
	localparam logic [14:0] STICK_THRESHOLD_RST = 15'd16384;
	localparam logic [19:0] REPEAT_DELAY_RST    = 20'd400000;
	localparam logic [19:0] REPEAT_INTERVAL_RST = 20'd120000;
	localparam logic [15:0] PRESS_MAP_RST       = 16'hFEDC;

	// commands per frame: one direction plus four press buttons
	localparam int MaxCmds = 5;
	localparam int CmdCountWidth = 3;

	// command queue depth between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef logic [2:0] cmd_t;

	// all commands that one frame produces
	typedef struct packed {
		logic [CmdCountWidth-1:0] n;
		cmd_t [MaxCmds-1:0]       cmds;
	} cmd_list_t;

	// queue status seen by front and back
	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

### rtl/core/nia_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nia_frame_if / nia_cmd_if
// Valid/ready channels for pad frames and emitted commands.
// ----------------------------------------------------------------------------
interface nia_frame_if;
	logic               valid;
	logic               ready;
	logic               pad_present;
	logic [3:0]         dpad_held;
	logic signed [15:0] stick_x;
	logic signed [15:0] stick_y;
	logic [3:0]         press_held;
	logic [19:0]        elapsed_us;

	modport source (output valid, pad_present, dpad_held, stick_x, stick_y, press_held,
		elapsed_us, input ready);
	modport sink (input valid, pad_present, dpad_held, stick_x, stick_y, press_held,
		elapsed_us, output ready);
endinterface

interface nia_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] command;
	logic       last;

	modport source (output valid, command, last, input ready);
	modport sink (input valid, command, last, output ready);
endinterface

`default_nettype wire

### rtl/core/nia_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nia_front
// Takes one pad frame, resolves the held direction, runs the repeat timer,
// finds press edges and builds the frame's command list.
// ----------------------------------------------------------------------------
module nia_front
	import nia_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [CfgDataWidth-1:0]  cfg_data,
	nia_frame_if.sink                     frame,
	input  wire q_status_t                q_status,
	output logic                          push,
	output cmd_list_t                     push_list
);

	localparam logic signed [20:0] TIMER_MIN = 21'sh100000;
	localparam logic signed [20:0] TIMER_MAX = 21'sh0FFFFF;

	logic [14:0]        thresh_q;
	logic [19:0]        delay_q;
	logic [19:0]        interval_q;
	logic [15:0]        press_map_q;
	logic [2:0]         held_q;
	logic signed [20:0] timer_q;
	logic [3:0]         prev_press_q;

	logic [15:0]        ax, ay, amax;
	logic [2:0]         stick_dir, dir;
	logic signed [21:0] diff, again, half, reload;
	logic signed [20:0] t_dec, t_rel, t_next;
	logic               dir_change, fire, emit_dir;
	logic [3:0]         press_edge;
	cmd_list_t          list;
	logic               xfer;

	function automatic logic signed [20:0] clamp_timer(input logic signed [21:0] v);
		if (v < $signed({TIMER_MIN[20], TIMER_MIN}))
			return TIMER_MIN;
		else if (v > $signed({TIMER_MAX[20], TIMER_MAX}))
			return TIMER_MAX;
		else
			return v[20:0];
	endfunction

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q    <= STICK_THRESHOLD_RST;
			delay_q     <= REPEAT_DELAY_RST;
			interval_q  <= REPEAT_INTERVAL_RST;
			press_map_q <= PRESS_MAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_STICK_THRESHOLD: thresh_q    <= cfg_data[14:0];
				CFG_REPEAT_DELAY:    delay_q     <= cfg_data;
				CFG_REPEAT_INTERVAL: interval_q  <= cfg_data;
				CFG_PRESS_MAP:       press_map_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// stick magnitudes, -32768 gives 32768
	assign ax   = frame.stick_x[15] ? (~frame.stick_x + 16'd1) : frame.stick_x;
	assign ay   = frame.stick_y[15] ? (~frame.stick_y + 16'd1) : frame.stick_y;
	assign amax = (ax > ay) ? ax : ay;

	// stick direction, ties go vertical
	always_comb begin
		if (amax < {1'b0, thresh_q})
			stick_dir = DIR_NONE;
		else if (ax > ay)
			stick_dir = (!frame.stick_x[15] && frame.stick_x != 16'sd0) ? DIR_RIGHT : DIR_LEFT;
		else
			stick_dir = (!frame.stick_y[15] && frame.stick_y != 16'sd0) ? DIR_DOWN : DIR_UP;
	end

	// d-pad wins with up, down, left, right priority
	always_comb begin
		if (frame.dpad_held[0])
			dir = DIR_UP;
		else if (frame.dpad_held[1])
			dir = DIR_DOWN;
		else if (frame.dpad_held[2])
			dir = DIR_LEFT;
		else if (frame.dpad_held[3])
			dir = DIR_RIGHT;
		else
			dir = stick_dir;
	end

	// repeat timer
	assign dir_change = (dir != held_q);
	assign diff   = {timer_q[20], timer_q} - {2'b00, frame.elapsed_us};
	assign t_dec  = clamp_timer(diff);
	assign fire   = (dir != DIR_NONE) && (t_dec[20] || t_dec == 21'sd0);
	assign again  = {t_dec[20], t_dec} + {2'b00, interval_q};
	assign half   = {3'b000, interval_q[19:1]};
	assign reload = (again > half) ? again : half;
	assign t_rel  = clamp_timer(reload);
	assign emit_dir = dir_change ? (dir != DIR_NONE) : fire;

	always_comb begin
		if (dir_change)
			t_next = {1'b0, delay_q};
		else if (fire)
			t_next = t_rel;
		else
			t_next = t_dec;
	end

	// press rising edges through the command map
	always_comb begin
		for (int b = 0; b < 4; b++)
			press_edge[b] = press_map_q[4*b+3] && frame.press_held[b] && !prev_press_q[b];
	end

	// pack the frame's commands in emission order
	always_comb begin
		list = '0;
		if (emit_dir) begin
			list.cmds[0] = dir;
			list.n       = CmdCountWidth'(1);
		end
		for (int b = 0; b < 4; b++) begin
			if (press_edge[b]) begin
				list.cmds[list.n] = press_map_q[4*b +: 3];
				list.n            = list.n + CmdCountWidth'(1);
			end
		end
	end

	assign frame.ready = !q_status.full;
	assign xfer        = frame.valid && frame.ready;
	assign push        = xfer && frame.pad_present && (list.n != '0);
	assign push_list   = list;

	// navigation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q       <= DIR_NONE;
			timer_q      <= {1'b0, REPEAT_DELAY_RST};
			prev_press_q <= '0;
		end else if (xfer) begin
			if (!frame.pad_present) begin
				held_q       <= DIR_NONE;
				timer_q      <= {1'b0, delay_q};
				prev_press_q <= '0;
			end else begin
				held_q       <= dir;
				timer_q      <= t_next;
				prev_press_q <= frame.press_held;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/nia_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nia_queue
// Short queue of per-frame command lists between front and back.
// ----------------------------------------------------------------------------
module nia_queue
	import nia_pkg::*;
#(
	parameter int Depth = QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire cmd_list_t wdata,
	input  wire logic      pop,
	output cmd_list_t      rdata,
	output q_status_t      status
);

	localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntWidth = $clog2(Depth + 1);
	localparam logic [PtrWidth-1:0] PtrLast = PtrWidth'(Depth - 1);
	localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

	cmd_list_t           mem [Depth];
	logic [PtrWidth-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntWidth-1:0] count_q;
	logic                do_push, do_pop;

	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CntFull);
	assign rdata        = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrWidth'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrWidth'(1);
			if (do_push && !do_pop)
				count_q <= count_q + CntWidth'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CntWidth'(1);
		end
	end

endmodule

`default_nettype wire

### rtl/core/nia_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nia_back
// Drains the head list, one command per cycle unless stalled, to the output reg.
// ----------------------------------------------------------------------------
module nia_back
	import nia_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cmd_list_t head,
	input  wire q_status_t q_status,
	output logic           pop,
	nia_cmd_if.source      cmd
);

	logic                     out_valid_q;
	cmd_t                     command_q;
	logic                     last_q;
	logic [CmdCountWidth-1:0] idx_q;
	logic                     load, take, is_last;

	assign load    = !out_valid_q || cmd.ready;
	assign take    = load && !q_status.empty;
	assign is_last = (idx_q == head.n - CmdCountWidth'(1));
	assign pop     = take && is_last;

	assign cmd.valid   = out_valid_q;
	assign cmd.command = command_q;
	assign cmd.last    = last_q;

	// output valid and list position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= !q_status.empty;
			if (take)
				idx_q <= is_last ? '0 : idx_q + CmdCountWidth'(1);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (take) begin
			command_q <= head.cmds[idx_q];
			last_q    <= is_last;
		end
	end

endmodule

`default_nettype wire

### rtl/core/nav_input_autorepeat.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nav_input_autorepeat
// Menu navigation commands from gamepad frames with held-direction repeat.
// ----------------------------------------------------------------------------
// frame channel: one pad frame per transfer; ready is high whenever the
//   command queue has room.
// cmd channel: one command per transfer, last marks the final command of
//   a frame; a frame gives zero to five commands.
// path: the first command of a frame goes through the queue write at the
//   transfer edge and then the output register load; the rest follow one
//   per cycle while cmd.ready is high.
// throughput: while cmd.ready is high the back drains one command per cycle
//   from the output register; the queue (QueueDepth lists) lets new frames be
//   taken while earlier lists still drain or the receiver stalls.
// stall: while cmd.ready is low the output register holds; once the queue
//   fills, frame.ready drops.
// reset: arst_n restores the configuration defaults, clears the held
//   direction, loads the timer with the default delay and empties the queue.
// cfg port: cfg_we writes cfg_data into register cfg_index, in order
//   threshold, delay, interval, press map; write only while idle.
// ----------------------------------------------------------------------------
module nav_input_autorepeat
	import nia_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CfgIndexWidth-1:0] cfg_index,
	input  wire logic [CfgDataWidth-1:0]  cfg_data,
	nia_frame_if.sink                     frame,
	nia_cmd_if.source                     cmd
);

	logic      push, pop;
	cmd_list_t push_list, head;
	q_status_t q_status;

	// front: classify frames
	nia_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.frame     (frame),
		.q_status  (q_status),
		.push      (push),
		.push_list (push_list)
	);

	// queue of command lists
	nia_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_list),
		.pop    (pop),
		.rdata  (head),
		.status (q_status)
	);

	// back: emit commands
	nia_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.cmd      (cmd)
	);

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_status.full))
		else $error("command list pushed into full queue");

	// a frame without a pad produces no commands
	a_absent_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(frame.valid && frame.ready && !frame.pad_present) |-> !push)
		else $error("commands queued for a frame with no pad");

	// a transfer that is not the last of its frame is followed by more
	a_list_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && !cmd.last) |=> cmd.valid)
		else $error("command list ended without last");

	// only lists with commands enter the queue
	a_nonempty_list: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_list.n != '0))
		else $error("empty command list queued");

endmodule

`default_nettype wire
